// ----- hw/rtl/sce_pkg.sv -----
package sce_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_T,
    S_EXP_MUL,
    S_EXP_WR,
    S_PL_RD,
    S_PL_DIV,
    S_PL_WAIT,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LOSS,
    S_MEAN,
    S_MEAN_WAIT,
    S_P_RD,
    S_P_DIV,
    S_P_WAIT,
    S_G_DIV,
    S_G_WAIT,
    S_OUT
  } state_t;

  localparam int ROOT_DEPTH = 15;
  typedef logic [31:0] root_tab_t [ROOT_DEPTH];

  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [39:0] LOSS_SUM_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [21:0] MEAN_MAX     = 22'h3F_FFFF;
  localparam logic [21:0] LOG2_FULL    = 22'd2097152;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [31:0] ACC_ONE      = 32'h8000_0000;
  localparam logic [15:0] PROB_MAX     = 16'hFFFF;
  localparam logic [15:0] LOGIT_MIN    = 16'h8000;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x = x_in;
    res = '0;
    for (int i = 0; i < 32; i++) begin
      bitv = 64'd1 << (62 - 2 * i);
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // r_k = 2^(-2^-k) in Q0.32
  function automatic root_tab_t make_roots();
    root_tab_t r;
    logic [63:0] s;
    r[0] = ACC_ONE;
    for (int k = 1; k < ROOT_DEPTH; k++) begin
      s = isqrt64({r[k-1], 32'd0});
      r[k] = s[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sce_div.sv -----
module sce_div #(
  parameter int DEN_W = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [6:0]       steps;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [63:0]      q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial    = {rem, q[63]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 7'd64;
      end else if (busy) begin
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      q <= {q[62:0], fits};
    end
  end

endmodule

// ----- hw/rtl/softmax_cross_entropy_core.sv -----
// Softmax cross-entropy core: logits of a row are taken one word per cycle while
// in_ready is high, up to MAX_CLASSES per row (extra ones are dropped). On the word
// marked row_end the core works through the row and then returns one result word per
// class, then takes the next row. A row of n classes goes through a load phase, an exp
// pass (one table root multiply per cycle), the label probability divide, a normalize
// and squaring loop for the log, a mean divide on a batch_end row, and a probability
// and a gradient divide per class; the shared 64-step restoring divider does all of
// these divides. batch_rows may be written only while the core is idle; zero counts
// as one.
module softmax_cross_entropy_core #(
  parameter int MAX_CLASSES    = 16,
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] logit,
  input  logic [3:0]         true_class,
  input  logic               row_end,
  input  logic               batch_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         class_index,
  output logic [15:0]        probability,
  output logic signed [15:0] gradient,
  output logic [21:0]        mean_loss,
  output logic               loss_valid,
  output logic               last_of_row
);

  localparam int IW    = $clog2(MAX_CLASSES);
  localparam int CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int LW    = (CNT_W > 4) ? CNT_W : 4;
  localparam int SUM_W = 32 + IW;
  localparam int RK_W  = $clog2(EXP_TABLE_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLASSES);
  localparam logic [RK_W-1:0]  RK_TOP  = RK_W'(EXP_TABLE_BITS);
  localparam sce_pkg::root_tab_t ROOT_TAB = sce_pkg::make_roots();

  sce_pkg::state_t state, state_next;

  logic [15:0]        row_store [MAX_CLASSES];
  logic [31:0]        exp_store [MAX_CLASSES];
  logic signed [15:0] row_rd;
  logic [31:0]        exp_rd;
  logic               row_we;
  logic               exp_we;
  logic [IW-1:0]      exp_raddr;

  logic [15:0]        batch_rows;
  logic [CNT_W-1:0]   cnt;
  logic signed [15:0] run_max;
  logic [3:0]         label;
  logic               bend;
  logic [39:0]        loss_sum;
  logic [CNT_W-1:0]   j;
  logic [32:0]        u_r;
  logic [RK_W-1:0]    rk;
  logic [31:0]        acc;
  logic [SUM_W-1:0]   sum;
  logic [32:0]        lx;
  logic [5:0]         lk;
  logic [31:0]        lm;
  logic [15:0]        lfrac;
  logic [3:0]         sq_n;
  logic [21:0]        mean_r;
  logic [15:0]        p_r;
  logic               neg_r;
  logic [15:0]        g_r;

  logic               in_fire;
  logic               slot_free;
  logic               label_in_row;
  logic               row_last;
  logic [15:0]        rows_eff;
  logic [16:0]        t_diff;
  logic [5:0]         bp;
  logic [63:0]        acc_prod;
  logic [31:0]        e_val;
  logic [63:0]        sq;
  logic [32:0]        sq_s;
  logic [21:0]        ldiff;
  logic [53:0]        loss_prod;
  logic [21:0]        loss;
  logic [40:0]        loss_add;
  logic               onehot;
  logic [16:0]        gmag;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [63:0]        div_num;
  logic [SUM_W-1:0]   div_den;
  logic [63:0]        div_q;

  sce_div #(.DEN_W(SUM_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_ready    = 1'b1;
  assign in_fire      = in_valid && in_ready;
  assign slot_free    = !out_valid || out_ready;
  assign label_in_row = LW'(label) < LW'(cnt);
  assign row_last     = (j + CNT_W'(1)) == cnt;
  assign rows_eff     = (batch_rows == '0) ? 16'd1 : batch_rows;
  assign t_diff       = 17'(run_max) - 17'(row_rd);
  assign bp           = 6'd24 - 6'(rk);
  assign acc_prod     = 64'(acc) * 64'(ROOT_TAB[4'(rk)]) + 64'(sce_pkg::ACC_ONE);
  assign e_val        = (u_r[32:29] != '0) ? 32'd0 : (acc >> u_r[28:24]);
  assign sq           = 64'(lm) * 64'(lm);
  assign sq_s         = sq[63:31];
  assign ldiff        = sce_pkg::LOG2_FULL - {lk[5:0], lfrac};
  assign loss_prod    = 54'(ldiff) * 54'(sce_pkg::LN2_Q32) + 54'(sce_pkg::ACC_ONE);
  assign loss         = loss_prod[53:32];
  assign loss_add     = 41'(loss_sum) + 41'(loss);
  assign onehot       = LW'(j) == LW'(label);
  assign gmag         = onehot ? (sce_pkg::ONE_Q16 - 17'(p_r)) : 17'(p_r);
  assign row_we       = in_fire && (cnt < CNT_MAX);
  assign exp_we       = state == sce_pkg::S_EXP_WR;
  assign exp_raddr    = (state == sce_pkg::S_PL_RD) ? IW'(label) : j[IW-1:0];

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_store[cnt[IW-1:0]] <= logit;
    end
    row_rd <= row_store[j[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_store[j[IW-1:0]] <= e_val;
    end
    exp_rd <= exp_store[exp_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      sce_pkg::S_IDLE:      if (in_fire && row_end) state_next = sce_pkg::S_EXP_RD;
      sce_pkg::S_EXP_RD:    state_next = sce_pkg::S_EXP_T;
      sce_pkg::S_EXP_T:     state_next = sce_pkg::S_EXP_MUL;
      sce_pkg::S_EXP_MUL:   if (rk == RK_W'(1)) state_next = sce_pkg::S_EXP_WR;
      sce_pkg::S_EXP_WR:    state_next = row_last ? sce_pkg::S_PL_RD : sce_pkg::S_EXP_RD;
      sce_pkg::S_PL_RD:     state_next = sce_pkg::S_PL_DIV;
      sce_pkg::S_PL_DIV:    state_next = label_in_row ? sce_pkg::S_PL_WAIT
                                                      : sce_pkg::S_LOG_NORM;
      sce_pkg::S_PL_WAIT:   if (div_done) state_next = sce_pkg::S_LOG_NORM;
      sce_pkg::S_LOG_NORM:  if (lx[32]) state_next = sce_pkg::S_LOG_SQ;
      sce_pkg::S_LOG_SQ:    if (sq_n == 4'd15) state_next = sce_pkg::S_LOSS;
      sce_pkg::S_LOSS:      state_next = bend ? sce_pkg::S_MEAN : sce_pkg::S_P_RD;
      sce_pkg::S_MEAN:      state_next = sce_pkg::S_MEAN_WAIT;
      sce_pkg::S_MEAN_WAIT: if (div_done) state_next = sce_pkg::S_P_RD;
      sce_pkg::S_P_RD:      state_next = sce_pkg::S_P_DIV;
      sce_pkg::S_P_DIV:     state_next = sce_pkg::S_P_WAIT;
      sce_pkg::S_P_WAIT:    if (div_done) state_next = sce_pkg::S_G_DIV;
      sce_pkg::S_G_DIV:     state_next = sce_pkg::S_G_WAIT;
      sce_pkg::S_G_WAIT:    if (div_done) state_next = sce_pkg::S_OUT;
      sce_pkg::S_OUT: begin
        if (slot_free) state_next = row_last ? sce_pkg::S_IDLE : sce_pkg::S_P_RD;
      end
      default:              state_next = sce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      sce_pkg::S_IDLE: in_ready = 1'b1;
      sce_pkg::S_PL_DIV: begin
        div_start = label_in_row;
        div_num   = {exp_rd, 32'd0};
        div_den   = sum;
      end
      sce_pkg::S_MEAN: begin
        div_start = 1'b1;
        div_num   = 64'(loss_sum);
        div_den   = SUM_W'(rows_eff);
      end
      sce_pkg::S_P_DIV: begin
        div_start = 1'b1;
        div_num   = {16'd0, exp_rd, 16'd0} + 64'(sum[SUM_W-1:1]);
        div_den   = sum;
      end
      sce_pkg::S_G_DIV: begin
        div_start = 1'b1;
        div_num   = 64'(gmag);
        div_den   = SUM_W'({rows_eff, 1'b0});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sce_pkg::S_IDLE;
      batch_rows <= 16'd1;
      cnt        <= '0;
      run_max    <= sce_pkg::LOGIT_MIN;
      label      <= '0;
      loss_sum   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        batch_rows <= cfg_data;
      end
      if (state == sce_pkg::S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        sce_pkg::S_IDLE: begin
          if (in_fire) begin
            label <= true_class;
            if (row_we) begin
              cnt <= cnt + CNT_W'(1);
              if (logit > run_max) run_max <= logit;
            end
          end
        end
        sce_pkg::S_LOSS: begin
          loss_sum <= (loss_add > 41'(sce_pkg::LOSS_SUM_MAX)) ? sce_pkg::LOSS_SUM_MAX
                                                              : loss_add[39:0];
        end
        sce_pkg::S_MEAN_WAIT: begin
          if (div_done) loss_sum <= '0;
        end
        sce_pkg::S_OUT: begin
          if (slot_free) begin
            if (row_last) begin
              cnt     <= '0;
              run_max <= sce_pkg::LOGIT_MIN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sce_pkg::S_IDLE: begin
        j      <= '0;
        sum    <= '0;
        mean_r <= '0;
        if (in_fire) bend <= batch_end;
      end
      sce_pkg::S_EXP_T: begin
        u_r <= 33'(t_diff[15:0]) * 33'(sce_pkg::LOG2E_Q16);
        rk  <= RK_TOP;
        acc <= sce_pkg::ACC_ONE;
      end
      sce_pkg::S_EXP_MUL: begin
        if (u_r[bp]) acc <= acc_prod[63:32];
        rk <= rk - RK_W'(1);
      end
      sce_pkg::S_EXP_WR: begin
        sum <= sum + SUM_W'(e_val);
        j   <= row_last ? '0 : j + CNT_W'(1);
      end
      sce_pkg::S_PL_RD: begin
        if (sum == '0) sum <= SUM_W'(1);
        lx <= 33'd1;
        lk <= 6'd32;
      end
      sce_pkg::S_PL_WAIT: begin
        if (div_done) lx <= (div_q[32:0] == '0) ? 33'd1 : div_q[32:0];
      end
      sce_pkg::S_LOG_NORM: begin
        if (lx[32]) begin
          lm    <= lx[32:1];
          sq_n  <= '0;
          lfrac <= '0;
        end else begin
          lx <= {lx[31:0], 1'b0};
          lk <= lk - 6'd1;
        end
      end
      sce_pkg::S_LOG_SQ: begin
        lm    <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
        lfrac <= {lfrac[14:0], sq_s[32]};
        sq_n  <= sq_n + 4'd1;
      end
      sce_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          mean_r <= (div_q > 64'(sce_pkg::MEAN_MAX)) ? sce_pkg::MEAN_MAX : div_q[21:0];
        end
      end
      sce_pkg::S_P_WAIT: begin
        if (div_done) p_r <= (div_q > 64'(sce_pkg::PROB_MAX)) ? sce_pkg::PROB_MAX
                                                              : div_q[15:0];
      end
      sce_pkg::S_G_DIV: neg_r <= onehot;
      sce_pkg::S_G_WAIT: begin
        if (div_done) g_r <= neg_r ? (16'd0 - div_q[15:0]) : div_q[15:0];
      end
      sce_pkg::S_OUT: begin
        if (slot_free) begin
          class_index <= 4'(j);
          probability <= p_r;
          gradient    <= g_r;
          last_of_row <= row_last;
          loss_valid  <= row_last && bend;
          mean_loss   <= (row_last && bend) ? mean_r : 22'd0;
          j           <= j + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX) else $error("element count beyond row capacity");

  a_loss_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && loss_valid) |-> last_of_row) else $error("mean loss not on last word");

  a_exp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sce_pkg::S_EXP_WR) |-> (acc <= sce_pkg::ACC_ONE))
    else $error("exp product above one");

  a_row_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == sce_pkg::S_EXP_RD) |-> (cnt != '0)) else $error("empty row processed");
`endif

endmodule
